/* rtl/ccl_pkg.sv */
`timescale 1ns / 1ps

package ccl_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int CONTACTOR_W   = 4;
  localparam int THRESHOLD_W   = 12;
  localparam int SPREAD_W      = 13;
  localparam int ATTEMPT_W     = 8;
  localparam int LIMIT_W       = THRESHOLD_W + CONTACTOR_W;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 13;

  localparam int SAMPLES_PER_GROUP_DEFAULT = 8;
  localparam int ADC_BITS_DEFAULT          = 12;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(100);
  localparam logic [SPREAD_W-1:0]    SPREAD_RESET    = SPREAD_W'(16);
  localparam logic [ATTEMPT_W-1:0]   ATTEMPTS_RESET  = ATTEMPT_W'(10);

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_CODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPREAD     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATTEMPTS   = 2'd2;

  typedef enum logic [1:0] {
    OUTCOME_STABLE    = 2'd0,
    OUTCOME_EXHAUSTED = 2'd1,
    OUTCOME_CONV_FAIL = 2'd2
  } outcome_t;

  typedef struct packed {
    logic                   cmd;
    logic [CONTACTOR_W-1:0] contactors_closed;
    logic [SAMPLE_W-1:0]    sample;
    logic                   conversion_ok;
  } item_t;

  typedef struct packed {
    logic                current_low;
    outcome_t            outcome;
    logic [SAMPLE_W-1:0] stable_code;
  } result_t;

endpackage

/* rtl/contactor_current_low_check.sv */
`timescale 1ns / 1ps

// channel  | signals                          | payload
// ---------+----------------------------------+---------------------------
// item     | item_valid, item_stall           | item   (ccl_pkg::item_t)
// result   | result_valid, result_stall       | result (ccl_pkg::result_t)
// config   | cfg_write, cfg_index, cfg_data   | one register per write
//
// one item per cycle while item_stall is low; a result comes from the input
// register, then the result register holding the finished check.
// min/max update, spread compare and threshold multiply are combinational.
// rst is synchronous and resets control, stats and config, not iq/result.
// item_stall rises only when the input register is full and the held result
// is stalled, so one item is still taken while a result waits.

module contactor_current_low_check #(
  parameter int SAMPLES_PER_GROUP = ccl_pkg::SAMPLES_PER_GROUP_DEFAULT,
  parameter int ADC_BITS          = ccl_pkg::ADC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  ccl_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output ccl_pkg::result_t                    result,
  input  logic                                cfg_write,
  input  logic [ccl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ccl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CODE_W = (ADC_BITS < ccl_pkg::SAMPLE_W) ? ADC_BITS : ccl_pkg::SAMPLE_W;
  localparam int GIDX_W = (SAMPLES_PER_GROUP > 2) ? $clog2(SAMPLES_PER_GROUP) : 1;
  localparam logic [GIDX_W-1:0] GROUP_LAST = GIDX_W'(SAMPLES_PER_GROUP - 1);

  logic [ccl_pkg::THRESHOLD_W-1:0] threshold_code;
  logic [ccl_pkg::SPREAD_W-1:0]    max_spread;
  logic [ccl_pkg::ATTEMPT_W-1:0]   max_attempts;

  logic                            iq_valid;
  ccl_pkg::item_t                  iq;

  logic                            busy, busy_next;
  logic [GIDX_W-1:0]               group_index, group_index_next;
  logic [CODE_W-1:0]               first_sample, first_sample_next;
  logic [CODE_W-1:0]               min_sample, min_sample_next;
  logic [CODE_W-1:0]               max_sample, max_sample_next;
  logic [ccl_pkg::ATTEMPT_W-1:0]   attempt_count, attempt_count_next;
  logic [ccl_pkg::CONTACTOR_W-1:0] contactor_count, contactor_count_next;

  logic                            advance;
  logic                            produce;
  ccl_pkg::result_t                result_next;

  logic [CODE_W-1:0]               code;
  logic [CODE_W-1:0]               spread;
  logic [ccl_pkg::CONTACTOR_W-1:0] scale;
  logic [ccl_pkg::LIMIT_W-1:0]     limit;
  logic [ccl_pkg::ATTEMPT_W-1:0]   attempt_inc;

  assign item_stall = iq_valid && result_valid && result_stall;
  assign advance    = iq_valid && !(result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_code <= ccl_pkg::THRESHOLD_RESET;
      max_spread     <= ccl_pkg::SPREAD_RESET;
      max_attempts   <= ccl_pkg::ATTEMPTS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ccl_pkg::CFG_THRESHOLD_CODE: threshold_code <= cfg_data[ccl_pkg::THRESHOLD_W-1:0];
        ccl_pkg::CFG_MAX_SPREAD:     max_spread     <= cfg_data[ccl_pkg::SPREAD_W-1:0];
        ccl_pkg::CFG_MAX_ATTEMPTS:   max_attempts   <= cfg_data[ccl_pkg::ATTEMPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      iq_valid <= 1'b1;
    end else if (advance) begin
      iq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      iq <= item;
    end
  end

  always_comb begin
    code   = iq.sample[CODE_W-1:0];
    scale  = (contactor_count == '0) ? ccl_pkg::CONTACTOR_W'(1) : contactor_count;
    attempt_inc = attempt_count + ccl_pkg::ATTEMPT_W'(1);

    busy_next            = busy;
    group_index_next     = group_index;
    first_sample_next    = first_sample;
    min_sample_next      = min_sample;
    max_sample_next      = max_sample;
    attempt_count_next   = attempt_count;
    contactor_count_next = contactor_count;
    produce              = 1'b0;
    result_next          = '0;

    // sample stats with the current transaction folded in
    if (group_index == '0) begin
      first_sample_next = code;
      min_sample_next   = code;
      max_sample_next   = code;
    end else begin
      if (code < min_sample) min_sample_next = code;
      if (code > max_sample) max_sample_next = code;
    end
    spread = max_sample_next - min_sample_next;
    limit  = ccl_pkg::LIMIT_W'(threshold_code) * ccl_pkg::LIMIT_W'(scale);

    if (iq.cmd == ccl_pkg::CMD_START) begin
      first_sample_next    = first_sample;
      min_sample_next      = min_sample;
      max_sample_next      = max_sample;
      contactor_count_next = iq.contactors_closed;
      group_index_next     = '0;
      attempt_count_next   = '0;
      busy_next            = 1'b1;
      if (max_attempts == '0) begin
        busy_next           = 1'b0;
        produce             = 1'b1;
        result_next.outcome = ccl_pkg::OUTCOME_EXHAUSTED;
      end
    end else if (!busy) begin
      first_sample_next = first_sample;
      min_sample_next   = min_sample;
      max_sample_next   = max_sample;
    end else if (!iq.conversion_ok) begin
      first_sample_next   = first_sample;
      min_sample_next     = min_sample;
      max_sample_next     = max_sample;
      busy_next           = 1'b0;
      group_index_next    = '0;
      produce             = 1'b1;
      result_next.outcome = ccl_pkg::OUTCOME_CONV_FAIL;
    end else if (group_index == GROUP_LAST) begin
      group_index_next = '0;
      if (ccl_pkg::SPREAD_W'(spread) < max_spread) begin
        busy_next               = 1'b0;
        produce                 = 1'b1;
        result_next.outcome     = ccl_pkg::OUTCOME_STABLE;
        result_next.stable_code = ccl_pkg::SAMPLE_W'(first_sample_next);
        result_next.current_low = ccl_pkg::LIMIT_W'(first_sample_next) <= limit;
      end else begin
        attempt_count_next = attempt_inc;
        if (attempt_inc >= max_attempts) begin
          busy_next           = 1'b0;
          produce             = 1'b1;
          result_next.outcome = ccl_pkg::OUTCOME_EXHAUSTED;
        end
      end
    end else begin
      group_index_next = group_index + GIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      group_index     <= '0;
      first_sample    <= '0;
      min_sample      <= '0;
      max_sample      <= '0;
      attempt_count   <= '0;
      contactor_count <= '0;
    end else if (advance) begin
      busy            <= busy_next;
      group_index     <= group_index_next;
      first_sample    <= first_sample_next;
      min_sample      <= min_sample_next;
      max_sample      <= max_sample_next;
      attempt_count   <= attempt_count_next;
      contactor_count <= contactor_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && produce) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      result <= result_next;
    end
  end

endmodule
